// ===== rtl/gama_pkg.sv =====
// ----------------------------------------------------------------------------
// gama_pkg
// Shared constants for the gap-aware moving average unit: default sizes,
// configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package gama_pkg;

    localparam int MAX_WINDOW_HALF = 8;
    localparam int SAMPLE_WIDTH    = 32;

    localparam int WINDOW_HALF_WIDTH = 4;
    localparam int CFG_DATA_WIDTH    = WINDOW_HALF_WIDTH;
    localparam int CFG_INDEX_WIDTH   = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_HALF = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FILL_ONLY   = 1'd1;

    localparam logic [WINDOW_HALF_WIDTH-1:0] WINDOW_HALF_RESET = 4'd5;
    localparam logic                         FILL_ONLY_RESET   = 1'b0;

endpackage

// ===== rtl/gama_sample_if.sv =====
// ----------------------------------------------------------------------------
// gama_sample_if
// Input channel: one sample request with its gap flag and end-of-sequence mark.
// ----------------------------------------------------------------------------
interface gama_sample_if #(
    parameter int SAMPLE_WIDTH = gama_pkg::SAMPLE_WIDTH
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic                           sample_valid;
    logic                           sample_last;

    modport source (
        output valid,
        output sample_value,
        output sample_valid,
        output sample_last,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample_value,
        input  sample_valid,
        input  sample_last,
        output ready
    );
endinterface

// ===== rtl/gama_avg_if.sv =====
// ----------------------------------------------------------------------------
// gama_avg_if
// Output channel: one averaged result request with its status flags.
// ----------------------------------------------------------------------------
interface gama_avg_if #(
    parameter int SAMPLE_WIDTH = gama_pkg::SAMPLE_WIDTH
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] avg_value;
    logic                           avg_valid;
    logic                           avg_last;
    logic                           any_changed;

    modport source (
        output valid,
        output avg_value,
        output avg_valid,
        output avg_last,
        output any_changed,
        input  ready
    );

    modport sink (
        input  valid,
        input  avg_value,
        input  avg_valid,
        input  avg_last,
        input  any_changed,
        output ready
    );
endinterface

// ===== rtl/gama_ram.sv =====
// ----------------------------------------------------------------------------
// gama_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module gama_ram #(
    parameter int WIDTH = gama_pkg::SAMPLE_WIDTH + 1,
    parameter int DEPTH = 2 * gama_pkg::MAX_WINDOW_HALF + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gama_div.sv =====
// ----------------------------------------------------------------------------
// gama_div
// Iterative restoring divider for unsigned operands, one quotient bit per
// cycle. Only the low QUO_WIDTH bits of the quotient are kept.
// ----------------------------------------------------------------------------
module gama_div #(
    parameter int NUM_WIDTH = gama_pkg::SAMPLE_WIDTH + 5,
    parameter int DEN_WIDTH = 5,
    parameter int QUO_WIDTH = gama_pkg::SAMPLE_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] numer,
    input  logic [DEN_WIDTH-1:0] denom,
    output logic                 done,
    output logic [QUO_WIDTH-1:0] quotient
);

    localparam int CountWidth = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0]  num_reg, num_next;
    logic [DEN_WIDTH-1:0]  den_reg, den_next;
    logic [DEN_WIDTH-1:0]  rem_reg, rem_next;
    logic [QUO_WIDTH-1:0]  quo_reg, quo_next;
    logic [CountWidth-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DEN_WIDTH:0] trial;
    logic [DEN_WIDTH:0] diff;
    logic               fits;

    // The partial remainder always stays below the divisor, so it fits in
    // DEN_WIDTH bits; the trial value needs one more.
    assign trial = {rem_reg, num_reg[NUM_WIDTH-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = ~diff[DEN_WIDTH];

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CountWidth'(NUM_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_WIDTH-2:0], 1'b0};
            rem_next = fits ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
            quo_next = {quo_reg[QUO_WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CountWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/gap_aware_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// gap_aware_moving_average_unit
// Centered moving average over a sample stream, skipping gap samples.
// ----------------------------------------------------------------------------
// The unit takes one sample request at a time and answers with the mean of
// the valid samples in a centered window of 2h+1 positions, h being the
// window_half register saturated at MAX_WINDOW_HALF; results trail the input
// by h samples, and the last sample of a sequence flushes the rest. Samples
// live in a circular buffer RAM of 2*MAX_WINDOW_HALF+1 entries with a fill
// count, so there is no clearing pass after reset. An accepted sample that
// produces no result leaves the unit idle and ready for the next one. Each
// result costs one RAM read per window position (c+h+1 reads for a center at
// offset c), and when a mean has to be formed the serial divider then runs
// over the sum. A finished result sits in an output register so the next
// sample can be taken while it waits.
// ----------------------------------------------------------------------------
module gap_aware_moving_average_unit #(
    parameter int MAX_WINDOW_HALF = gama_pkg::MAX_WINDOW_HALF,
    parameter int SAMPLE_WIDTH    = gama_pkg::SAMPLE_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [gama_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [gama_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    gama_sample_if.sink                          samples,
    gama_avg_if.source                           averages
);

    localparam int StoreDepth = 2 * MAX_WINDOW_HALF + 1;
    localparam int AW         = $clog2(StoreDepth);
    localparam int FW         = $clog2(StoreDepth + 1);
    localparam int HW         = $clog2(MAX_WINDOW_HALF + 1);
    localparam int SumWidth   = SAMPLE_WIDTH + FW;
    localparam int WordWidth  = SAMPLE_WIDTH + 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_CALC   = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [gama_pkg::WINDOW_HALF_WIDTH-1:0] window_half_reg, window_half_next;
    logic                                   fill_only_reg, fill_only_next;

    // Sequence state
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] base_reg, base_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          changed_reg, changed_next;

    // Per-item and per-result working registers
    logic                       last_reg, last_next;
    logic [HW-1:0]              h_reg, h_next;
    logic [HW-1:0]              c_reg, c_next;
    logic [AW-1:0]              k_reg, k_next;
    logic                       issue_reg, issue_next;
    logic                       pend_reg, pend_next;
    logic                       pend_in_range_reg, pend_in_range_next;
    logic                       pend_center_reg, pend_center_next;
    logic signed [SumWidth-1:0] sum_reg, sum_next;
    logic [FW-1:0]              count_reg, count_next;
    logic [SAMPLE_WIDTH-1:0]    center_value_reg, center_value_next;
    logic                       center_valid_reg, center_valid_next;
    logic                       neg_reg, neg_next;
    logic [SAMPLE_WIDTH-1:0]    res_value_reg, res_value_next;
    logic                       res_valid_reg, res_valid_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] out_value_reg, out_value_next;
    logic                    out_avg_valid_reg, out_avg_valid_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_changed_reg, out_changed_next;

    // RAM and divider connections
    logic                 ram_we;
    logic [WordWidth-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WordWidth-1:0] ram_rdata;
    logic                 div_start;
    logic [SumWidth-1:0]  div_numer;
    logic                 div_done;
    logic [SAMPLE_WIDTH-1:0] div_quotient;

    logic                          in_accept;
    logic [HW-1:0]                 h_eff;
    logic [HW-1:0]                 seen;
    logic [AW-1:0]                 hi;
    logic [AW:0]                   addr_wide;
    logic signed [SAMPLE_WIDTH-1:0] rd_value;
    logic                          rd_valid;
    logic [SumWidth-1:0]           sum_mag;
    logic                          out_load;
    logic                          final_result;

    gama_ram #(
        .WIDTH (WordWidth),
        .DEPTH (StoreDepth)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gama_div #(
        .NUM_WIDTH (SumWidth),
        .DEN_WIDTH (FW),
        .QUO_WIDTH (SAMPLE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_accept     = samples.valid && samples.ready;

    assign ram_we    = in_accept;
    assign ram_wdata = {samples.sample_valid, samples.sample_value};

    assign h_eff = (int'(window_half_reg) > MAX_WINDOW_HALF) ? HW'(MAX_WINDOW_HALF)
                                                             : HW'(window_half_reg);
    assign seen  = (int'(fill_reg) >= MAX_WINDOW_HALF) ? HW'(MAX_WINDOW_HALF)
                                                       : HW'(fill_reg);
    assign hi    = AW'(c_reg) + AW'(h_reg);

    // Offset k back from the newest entry, wrapped around the circular buffer.
    assign addr_wide = ({1'b0, base_reg} >= {1'b0, k_reg})
                     ? ({1'b0, base_reg} - {1'b0, k_reg})
                     : ({1'b0, base_reg} + (AW+1)'(StoreDepth) - {1'b0, k_reg});
    assign ram_raddr = addr_wide[AW-1:0];

    assign rd_value = ram_rdata[SAMPLE_WIDTH-1:0];
    assign rd_valid = ram_rdata[SAMPLE_WIDTH];

    assign sum_mag   = sum_reg[SumWidth-1] ? SumWidth'(-sum_reg) : SumWidth'(sum_reg);
    assign div_numer = sum_mag + SumWidth'(count_reg >> 1);

    assign final_result = last_reg && (c_reg == '0);
    assign out_load     = (state_reg == ST_EMIT) && (!out_valid_reg || averages.ready);

    always_comb
    begin
        state_next         = state_reg;
        window_half_next   = window_half_reg;
        fill_only_next     = fill_only_reg;
        wptr_next          = wptr_reg;
        base_next          = base_reg;
        fill_next          = fill_reg;
        changed_next       = changed_reg;
        last_next          = last_reg;
        h_next             = h_reg;
        c_next             = c_reg;
        k_next             = k_reg;
        issue_next         = issue_reg;
        pend_next          = 1'b0;
        pend_in_range_next = pend_in_range_reg;
        pend_center_next   = pend_center_reg;
        sum_next           = sum_reg;
        count_next         = count_reg;
        center_value_next  = center_value_reg;
        center_valid_next  = center_valid_reg;
        neg_next           = neg_reg;
        res_value_next     = res_value_reg;
        res_valid_next     = res_valid_reg;
        div_start          = 1'b0;

        if (cfg_write_en)
        begin
            unique case (cfg_index)
                gama_pkg::CFG_WINDOW_HALF:
                    window_half_next = cfg_data[gama_pkg::WINDOW_HALF_WIDTH-1:0];
                gama_pkg::CFG_FILL_ONLY:
                    fill_only_next = cfg_data[0];
                default:
                    ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    base_next = wptr_reg;
                    wptr_next = (int'(wptr_reg) == StoreDepth - 1) ? '0 : wptr_reg + 1'b1;
                    fill_next = (int'(fill_reg) == StoreDepth) ? fill_reg : fill_reg + 1'b1;
                    last_next = samples.sample_last;
                    h_next    = h_eff;
                    c_next    = (seen < h_eff) ? seen : h_eff;
                    k_next             = '0;
                    issue_next         = 1'b1;
                    sum_next           = '0;
                    count_next         = '0;
                    center_valid_next  = 1'b0;
                    if (samples.sample_last || (seen >= h_eff))
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    issue_next = (k_reg != hi);
                    pend_next  = 1'b1;
                end
                pend_in_range_next = FW'(k_reg) < fill_reg;
                pend_center_next   = (k_reg == AW'(c_reg));
                // Read data arrives in the cycle after the address was issued.
                if (pend_reg)
                begin
                    if (rd_valid && pend_in_range_reg)
                    begin
                        sum_next   = sum_reg + SumWidth'(rd_value);
                        count_next = count_reg + 1'b1;
                    end
                    if (pend_center_reg)
                    begin
                        center_value_next = rd_value;
                        center_valid_next = rd_valid && pend_in_range_reg;
                    end
                    if (!issue_reg)
                    begin
                        state_next = ST_CALC;
                    end
                end
            end

            ST_CALC:
            begin
                if (fill_only_reg && center_valid_reg)
                begin
                    res_value_next = center_value_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    changed_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        res_value_next = '0;
                        res_valid_next = 1'b0;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        neg_next   = sum_reg[SumWidth-1];
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    res_value_next = neg_reg ? -div_quotient : div_quotient;
                    res_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_load)
                begin
                    if (last_reg && (c_reg != '0))
                    begin
                        // Flush: move the center one position toward the newest.
                        c_next            = c_reg - 1'b1;
                        k_next            = '0;
                        issue_next        = 1'b1;
                        sum_next          = '0;
                        count_next        = '0;
                        center_valid_next = 1'b0;
                        state_next        = ST_SCAN;
                    end
                    else
                    begin
                        if (last_reg)
                        begin
                            fill_next    = '0;
                            changed_next = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next     = out_valid_reg;
        out_value_next     = out_value_reg;
        out_avg_valid_next = out_avg_valid_reg;
        out_last_next      = out_last_reg;
        out_changed_next   = out_changed_reg;
        if (out_load)
        begin
            out_valid_next     = 1'b1;
            out_value_next     = res_value_reg;
            out_avg_valid_next = res_valid_reg;
            out_last_next      = final_result;
            out_changed_next   = final_result && changed_reg;
        end
        else if (averages.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_half_reg <= gama_pkg::WINDOW_HALF_RESET;
            fill_only_reg   <= gama_pkg::FILL_ONLY_RESET;
            wptr_reg        <= '0;
            base_reg        <= '0;
            fill_reg        <= '0;
            changed_reg     <= 1'b0;
            issue_reg       <= 1'b0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_half_reg <= window_half_next;
            fill_only_reg   <= fill_only_next;
            wptr_reg        <= wptr_next;
            base_reg        <= base_next;
            fill_reg        <= fill_next;
            changed_reg     <= changed_next;
            issue_reg       <= issue_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg          <= last_next;
        h_reg             <= h_next;
        c_reg             <= c_next;
        k_reg             <= k_next;
        pend_in_range_reg <= pend_in_range_next;
        pend_center_reg   <= pend_center_next;
        sum_reg           <= sum_next;
        count_reg         <= count_next;
        center_value_reg  <= center_value_next;
        center_valid_reg  <= center_valid_next;
        neg_reg           <= neg_next;
        res_value_reg     <= res_value_next;
        res_valid_reg     <= res_valid_next;
        out_value_reg     <= out_value_next;
        out_avg_valid_reg <= out_avg_valid_next;
        out_last_reg      <= out_last_next;
        out_changed_reg   <= out_changed_next;
    end

    assign averages.valid       = out_valid_reg;
    assign averages.avg_value   = out_value_reg;
    assign averages.avg_valid   = out_avg_valid_reg;
    assign averages.avg_last    = out_last_reg;
    assign averages.any_changed = out_changed_reg;

endmodule

// ===== verif/gama_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gama_checker
// Watches the sample and average channels and the register write port of the
// gap-aware moving average unit, predicts every average request from the
// samples it sees, and compares field by field in arrival order.
// ----------------------------------------------------------------------------
module gama_checker
    import gama_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    gama_sample_if                     samples,
    gama_avg_if                        averages,
    output int                         failures,
    output int                         pending
);

    localparam int STORE_DEPTH = 2 * MAX_WINDOW_HALF + 1;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                           valid;
        logic                           last;
        logic                           changed;
    } avg_result_t;

    avg_result_t                    expected_avgs[$];
    logic signed [SAMPLE_WIDTH-1:0] hist_value[STORE_DEPTH];
    logic                           hist_valid[STORE_DEPTH];
    int                             fill_level;
    logic                           seq_changed;
    logic [WINDOW_HALF_WIDTH-1:0]   half_reg;
    logic                           fill_only_reg;
    int                             err_count = 0;

    function automatic void clear_sequence();
        int k;
        for (k = 0; k < STORE_DEPTH; k++)
        begin
            hist_value[k] = '0;
            hist_valid[k] = 1'b0;
        end
        fill_level  = 0;
        seq_changed = 1'b0;
    endfunction

    // Valid center in fill-only mode, else mean of valid samples within half of it.
    function automatic void predict_average(int center, int half, logic is_last);
        avg_result_t r;
        longint      sum;
        longint      quo;
        int          count;
        int          lo;
        int          hi;
        int          k;
        r.value = '0;
        r.valid = 1'b0;
        if (fill_only_reg && hist_valid[center])
        begin
            r.value = hist_value[center];
            r.valid = 1'b1;
        end
        else
        begin
            seq_changed = 1'b1;
            sum   = 0;
            count = 0;
            lo    = (center > half) ? center - half : 0;
            hi    = center + half;
            if (hi > STORE_DEPTH - 1)
                hi = STORE_DEPTH - 1;
            for (k = lo; k <= hi; k++)
            begin
                if (hist_valid[k])
                begin
                    sum += hist_value[k];
                    count++;
                end
            end
            if (count > 0)
            begin
                // Round half away from zero on the magnitude.
                quo = ((sum < 0 ? -sum : sum) + count / 2) / count;
                if (sum < 0)
                    quo = -quo;
                r.value = quo[SAMPLE_WIDTH-1:0];
                r.valid = 1'b1;
            end
        end
        r.last    = is_last;
        r.changed = is_last && seq_changed;
        expected_avgs.push_back(r);
    endfunction

    function automatic void predict_sample(logic signed [SAMPLE_WIDTH-1:0] value,
                                           logic present, logic is_last);
        int half;
        int seen;
        int k;
        int c;
        half = (half_reg > MAX_WINDOW_HALF) ? MAX_WINDOW_HALF : int'(half_reg);
        seen = fill_level;
        for (k = STORE_DEPTH - 1; k > 0; k--)
        begin
            hist_value[k] = hist_value[k-1];
            hist_valid[k] = hist_valid[k-1];
        end
        hist_valid[0] = present;
        hist_value[0] = present ? value : '0;
        if (!is_last)
        begin
            if (seen >= half)
                predict_average(half, half, 1'b0);
            if (fill_level < MAX_WINDOW_HALF)
                fill_level++;
        end
        else
        begin
            // The last sample flushes every position still held back.
            for (c = (seen < half) ? seen : half; c >= 0; c--)
                predict_average(c, half, c == 0);
            clear_sequence();
        end
    endfunction

    function automatic void check_average(avg_result_t got);
        avg_result_t want;
        if (expected_avgs.size() == 0)
        begin
            $error("unexpected average request: avg_value %0d avg_valid %0b avg_last %0b",
                   got.value, got.valid, got.last);
            err_count++;
            return;
        end
        want = expected_avgs.pop_front();
        if (got.value !== want.value)
        begin
            $error("avg_value: expected %0d, got %0d", want.value, got.value);
            err_count++;
        end
        if (got.valid !== want.valid)
        begin
            $error("avg_valid: expected %0b, got %0b", want.valid, got.valid);
            err_count++;
        end
        if (got.last !== want.last)
        begin
            $error("avg_last: expected %0b, got %0b", want.last, got.last);
            err_count++;
        end
        if (got.changed !== want.changed)
        begin
            $error("any_changed: expected %0b, got %0b", want.changed, got.changed);
            err_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        avg_result_t got;
        if (!rst_n)
        begin
            clear_sequence();
            half_reg      = WINDOW_HALF_RESET;
            fill_only_reg = FILL_ONLY_RESET;
            expected_avgs.delete();
        end
        else
        begin
            if (averages.valid && averages.ready)
            begin
                got.value   = averages.avg_value;
                got.valid   = averages.avg_valid;
                got.last    = averages.avg_last;
                got.changed = averages.any_changed;
                check_average(got);
            end
            if (samples.valid && samples.ready)
                predict_sample(samples.sample_value, samples.sample_valid,
                               samples.sample_last);
            if (cfg_write_en)
            begin
                if (cfg_index == CFG_WINDOW_HALF)
                    half_reg = cfg_data[WINDOW_HALF_WIDTH-1:0];
                else if (cfg_index == CFG_FILL_ONLY)
                    fill_only_reg = cfg_data[0];
            end
        end
        failures <= err_count;
        pending  <= expected_avgs.size();
    end

endmodule

// ===== verif/gap_aware_moving_average_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gap_aware_moving_average_unit_test
// Drives sample sequences with gaps into the moving average unit under
// several window and fill settings, stalls both channels at random, and
// relies on the checker beside the unit for the comparison.
// ----------------------------------------------------------------------------
module gap_aware_moving_average_unit_test;
    import gama_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 64;
    localparam int END_CYCLES    = 200;
    localparam int RANDOM_ITEMS  = 80;

    localparam logic signed [SAMPLE_WIDTH-1:0] MAX_SAMPLE = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write_en;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    int                         failures;
    int                         pending;
    int                         idle_cycles;
    bit                         steady_sender;

    gama_sample_if samples_ch ();
    gama_avg_if    averages_ch ();

    gap_aware_moving_average_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .samples      (samples_ch),
        .averages     (averages_ch)
    );

    gama_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .samples      (samples_ch),
        .averages     (averages_ch),
        .failures     (failures),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return MAX_SAMPLE;
            1: return MIN_SAMPLE;
            2: return '0;
            3: return '1;
            // Small values make rounding ties likely.
            4, 5: return SAMPLE_WIDTH'(int'($urandom_range(0, 16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] value,
                               input logic present, input logic is_last);
        int gap;
        gap = steady_sender ? 0 : idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid        <= 1'b1;
        samples_ch.sample_value <= value;
        samples_ch.sample_valid <= present;
        samples_ch.sample_last  <= is_last;
        do
            @(posedge clk);
        while (!samples_ch.ready);
    endtask

    // Wait until every expected average has come back, then let the unit settle.
    task automatic drain(input int settle);
        @(negedge clk);
        samples_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                  input logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        int run_len;
        int stall;
        averages_ch.ready = 1'b0;
        forever
        begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
            repeat (run_len) @(negedge clk) averages_ch.ready <= 1'b1;
            stall = idle_length();
            repeat (stall) @(negedge clk) averages_ch.ready <= 1'b0;
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((samples_ch.valid && samples_ch.ready) ||
                (averages_ch.valid && averages_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("gap_aware_moving_average_unit regression: fail");
        $finish;
    end

    initial
    begin
        int                         random_sent;
        int                         phase;
        int                         phase_end;
        int                         seq_len;
        int                         gap_pct;
        int                         i;
        logic [WINDOW_HALF_WIDTH-1:0] half;
        logic                       fill;
        rst_n                   = 1'b0;
        cfg_write_en            = 1'b0;
        cfg_index               = CFG_WINDOW_HALF;
        cfg_data                = '0;
        samples_ch.valid        = 1'b0;
        samples_ch.sample_value = '0;
        samples_ch.sample_valid = 1'b0;
        samples_ch.sample_last  = 1'b0;
        steady_sender           = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a sequence no longer than the half window, both extremes,
        // and a gap as the last sample.
        send_sample(MAX_SAMPLE, 1'b1, 1'b0);
        send_sample(MAX_SAMPLE, 1'b1, 1'b0);
        send_sample(MIN_SAMPLE, 1'b1, 1'b0);
        send_sample(random_value(), 1'b0, 1'b0);
        send_sample(random_value(), 1'b0, 1'b1);

        // No window at all with fill-only: gaps give empty windows, valid samples
        // pass through, and a gap-free sequence reports nothing recomputed.
        drain(SETTLE_CYCLES);
        write_register(CFG_WINDOW_HALF, 4'd0);
        write_register(CFG_FILL_ONLY, 4'b1111);
        send_sample(random_value(), 1'b0, 1'b0);
        send_sample('1, 1'b1, 1'b0);
        send_sample(random_value(), 1'b0, 1'b1);
        send_sample(SAMPLE_WIDTH'(5), 1'b1, 1'b0);
        send_sample(-SAMPLE_WIDTH'(3), 1'b1, 1'b1);

        // Half width above the maximum saturates; a one-sample sequence.
        drain(SETTLE_CYCLES);
        write_register(CFG_WINDOW_HALF, 4'd15);
        write_register(CFG_FILL_ONLY, 4'b0000);
        send_sample(MIN_SAMPLE, 1'b1, 1'b1);

        // Rounding ties on both signs, then a register change mid-sequence.
        send_sample(SAMPLE_WIDTH'(1), 1'b1, 1'b0);
        send_sample(SAMPLE_WIDTH'(2), 1'b1, 1'b0);
        send_sample('1, 1'b1, 1'b0);
        send_sample(-SAMPLE_WIDTH'(2), 1'b1, 1'b0);
        send_sample(random_value(), 1'b0, 1'b0);
        send_sample(SAMPLE_WIDTH'(7), 1'b1, 1'b0);
        send_sample(-SAMPLE_WIDTH'(7), 1'b1, 1'b0);
        send_sample(SAMPLE_WIDTH'(3), 1'b1, 1'b0);
        send_sample(SAMPLE_WIDTH'(4), 1'b1, 1'b0);
        send_sample(MAX_SAMPLE, 1'b1, 1'b0);
        drain(SETTLE_CYCLES);
        write_register(CFG_WINDOW_HALF, 4'd2);
        write_register(CFG_FILL_ONLY, 4'b0011);
        send_sample(random_value(), 1'b0, 1'b0);
        send_sample(SAMPLE_WIDTH'(6), 1'b1, 1'b1);

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case (phase)
                0: begin half = 4'd8;  fill = 1'b0; end
                1: begin half = 4'd0;  fill = 1'b1; end
                2: begin half = 4'd12; fill = 1'b1; end
                3: begin half = 4'd1;  fill = 1'b0; end
                default:
                begin
                    half = WINDOW_HALF_WIDTH'($urandom_range(0, 15));
                    fill = 1'($urandom_range(0, 1));
                end
            endcase
            drain(SETTLE_CYCLES);
            write_register(CFG_WINDOW_HALF, half);
            write_register(CFG_FILL_ONLY, {3'($urandom_range(0, 7)), fill});
            phase_end = random_sent + $urandom_range(10, 20);
            while (random_sent < phase_end)
            begin
                seq_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
                                                     : $urandom_range(13, 28);
                case ($urandom_range(0, 19))
                    0, 1, 2:       gap_pct = 100;
                    3, 4, 5, 6, 7: gap_pct = 0;
                    default:       gap_pct = 30;
                endcase
                steady_sender = ($urandom_range(0, 3) == 0);
                for (i = 0; i < seq_len; i++)
                begin
                    send_sample(random_value(), $urandom_range(0, 99) >= gap_pct,
                                i == seq_len - 1);
                    random_sent++;
                end
            end
            phase++;
        end
        steady_sender = 1'b0;

        drain(END_CYCLES);
        if (failures == 0)
            $display("gap_aware_moving_average_unit regression: pass");
        else
            $display("gap_aware_moving_average_unit regression: fail");
        $finish;
    end

endmodule
